// ===== rtl/kbst_pkg.sv =====
package kbst_pkg;

  localparam int unsigned SlotsDefault     = 64;
  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned KeyW             = 64;
  localparam int unsigned SlotW            = 6;

  typedef enum logic [2:0] {
    CMD_ACQUIRE  = 3'd0,
    CMD_RELEASE  = 3'd1,
    CMD_DIRTY    = 3'd2,
    CMD_WB_ONE   = 3'd3,
    CMD_RELOAD   = 3'd4,
    CMD_WB_ALL   = 3'd5,
    CMD_RELD_ALL = 3'd6,
    CMD_QUERY    = 3'd7
  } cmd_e;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StInvalid = 2'd2;

  localparam logic [1:0] IoNone  = 2'd0;
  localparam logic [1:0] IoRead  = 2'd1;
  localparam logic [1:0] IoWrite = 2'd2;

  // token handed along the row of cells
  typedef struct packed {
    logic             act;     // a command is passing this cell
    logic [2:0]       cmd;
    logic [KeyW-1:0]  key;
    logic [SlotW-1:0] slot;
    logic             wb_en;
    logic             found;   // acquire already hit upstream
    logic             free_ok; // an earlier free slot exists
    logic [SlotW-1:0] free_idx;
  } tok_t;

  // per-cell report to the controller
  typedef struct packed {
    logic             emit;
    logic [1:0]       status;
    logic [SlotW-1:0] slot;
    logic [KeyW-1:0]  key;
    logic [1:0]       io_op;
    logic             hit;     // acquire hit here
    logic             free;    // cell is free for a claim
  } rep_t;

endpackage

// ===== rtl/keyed_buffer_slot_table_top.sv =====
// keyed buffer slot table: reference-counted table of buffer slots
// input channel: in_valid_i / in_stall_o with cmd_i, key_i, slot_i
// output channel: out_valid_o / out_stall_i with status_o, slot_out_o,
//   key_out_o, io_op_o, last_o; last_o marks the final word of a command
// config channel: cfg_valid_i / cfg_ready_o with cfg_data_i, writes the
//   write-back enable (reset 1); write only while the block is idle
// the slots form a row of cells; a command token walks the row one cell
//   a cycle while the output is not stalled, then a closing step claims a
//   slot on an acquire miss or sends the closing word
// one command at a time: in_stall_o is high from acceptance until the
//   closing step is done
// a word for a slot command or an acquire hit goes out while the token
//   passes that cell; a miss, full or out-of-range word in the closing step
// the "all" commands emit one word per valid dirty slot, in slot order;
//   write-back-all only with write-back on; each word is held back until
//   the next or the row end, so the last has last_o; if none, one empty word
// while the output register is full and stalled the row pauses and no slot
//   state changes
// reset clears every slot (key, valid, count, dirty) at once
module keyed_buffer_slot_table_top #(
  parameter int unsigned Slots     = kbst_pkg::SlotsDefault,
  parameter int unsigned CountBits = kbst_pkg::CountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] key_i,
  input  logic [5:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_out_o,
  output logic [63:0] key_out_o,
  output logic [1:0]  io_op_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int unsigned PosW = $clog2(Slots);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_CLAIM} state_e;

  state_e               state_q;
  logic [PosW-1:0]      pos_q;     // cell the token is at
  logic                 wb_en_q;
  logic                 any_q;     // a sweep word is held back
  kbst_pkg::tok_t       head_q;    // injected token
  logic                 ov_q;      // output register
  logic [1:0]           st_q, io_q;
  logic [5:0]           sl_q;
  logic [63:0]          ky_q;
  logic                 ls_q;
  // held-back sweep word
  logic [1:0]           pio_q;
  logic [5:0]           psl_q;
  logic [63:0]          pky_q;

  kbst_pkg::tok_t tok_in  [Slots];
  kbst_pkg::tok_t tok_out [Slots];
  kbst_pkg::rep_t rep     [Slots];
  logic [Slots-1:0] claim;

  kbst_pkg::rep_t cur;
  kbst_pkg::tok_t tail;
  kbst_pkg::tok_t inject;
  logic           step, at_end, out_free;
  logic           is_sweep, is_acq, slot_oor, miss;
  logic           walk_load, claim_load;

  assign out_free = !ov_q || !out_stall_i;
  assign at_end   = (pos_q == PosW'(Slots - 1));
  assign cur      = rep[pos_q];
  assign tail     = tok_out[Slots-1];

  assign is_sweep = (head_q.cmd == kbst_pkg::CMD_WB_ALL) ||
                    (head_q.cmd == kbst_pkg::CMD_RELD_ALL);
  assign is_acq   = (head_q.cmd == kbst_pkg::CMD_ACQUIRE);
  assign slot_oor = (7'(head_q.slot) >= 7'(Slots));
  assign miss     = is_acq && !tail.found;

  // the row only moves when the output register can take a word
  assign step = (state_q == S_WALK) && out_free;

  // a word enters the output register this cycle
  assign walk_load  = step && (cur.hit || (cur.emit && (!is_sweep || any_q)));
  assign claim_load = (state_q == S_CLAIM) && out_free &&
                      (is_sweep || miss || (!is_acq && slot_oor));

  always_comb begin
    inject       = '0;
    inject.act   = 1'b1;
    inject.cmd   = cmd_i;
    inject.key   = key_i;
    inject.slot  = slot_i;
    inject.wb_en = wb_en_q;
  end

  genvar g;
  for (g = 0; g < Slots; g++) begin : g_row
    if (g == 0) begin : g_head
      assign tok_in[g] = (step && pos_q == '0) ? head_q : '0;
    end else begin : g_link
      // token is gated so the whole row holds when stalled
      assign tok_in[g] = (step && pos_q == PosW'(g)) ? tok_out[g-1] : '0;
    end
    assign claim[g] = (state_q == S_CLAIM) && out_free && miss &&
                      tail.free_ok && (tail.free_idx == kbst_pkg::SlotW'(g));
    kbst_cell #(.CountBits(CountBits), .Index(g)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok_in[g]),
      .claim_i     (claim[g]),
      .claim_key_i (head_q.key),
      .tok_o       (tok_out[g]),
      .rep_o       (rep[g])
    );
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      wb_en_q <= 1'b1;
      any_q   <= 1'b0;
      head_q  <= '0;
      ov_q    <= 1'b0;
      st_q    <= '0;
      io_q    <= '0;
      sl_q    <= '0;
      ky_q    <= '0;
      ls_q    <= 1'b0;
      pio_q   <= '0;
      psl_q   <= '0;
      pky_q   <= '0;
    end else begin
      ov_q <= walk_load || claim_load || (ov_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i && cfg_ready_o) wb_en_q <= cfg_data_i;
          if (in_valid_i) begin
            head_q  <= inject;
            pos_q   <= '0;
            any_q   <= 1'b0;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (out_free) begin
            if (cur.emit && is_sweep) begin
              // send the held word on, hold this one back
              if (any_q) begin
                st_q <= kbst_pkg::StOk;
                sl_q <= psl_q;
                ky_q <= pky_q;
                io_q <= pio_q;
                ls_q <= 1'b0;
              end
              psl_q <= cur.slot;
              pky_q <= cur.key;
              pio_q <= cur.io_op;
              any_q <= 1'b1;
            end else if (cur.emit || cur.hit) begin
              st_q <= cur.status;
              sl_q <= cur.slot;
              ky_q <= cur.hit ? head_q.key : cur.key;
              io_q <= cur.io_op;
              ls_q <= 1'b1;
            end
            if (at_end) state_q <= S_CLAIM;
            else pos_q <= pos_q + PosW'(1);
          end
        end
        S_CLAIM: begin
          if (out_free) begin
            state_q <= S_IDLE;
            if (is_sweep) begin
              // last word of a sweep goes out here, or an empty word
              st_q <= kbst_pkg::StOk;
              ls_q <= 1'b1;
              if (any_q) begin
                sl_q <= psl_q;
                ky_q <= pky_q;
                io_q <= pio_q;
              end else begin
                sl_q <= '0;
                ky_q <= '0;
                io_q <= kbst_pkg::IoNone;
              end
            end else if (miss) begin
              ky_q <= head_q.key;
              ls_q <= 1'b1;
              if (tail.free_ok) begin
                st_q <= kbst_pkg::StOk;
                sl_q <= tail.free_idx;
                io_q <= kbst_pkg::IoRead;
              end else begin
                st_q <= kbst_pkg::StFull;
                sl_q <= '0;
                io_q <= kbst_pkg::IoNone;
              end
            end else if (!is_acq && slot_oor) begin
              st_q <= kbst_pkg::StInvalid;
              sl_q <= head_q.slot;
              ky_q <= '0;
              io_q <= kbst_pkg::IoNone;
              ls_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign slot_out_o  = sl_q;
  assign key_out_o   = ky_q;
  assign io_op_o     = io_q;
  assign last_o      = ls_q;

endmodule

// ===== rtl/kbst_cell.sv =====
module kbst_cell #(
  parameter int unsigned CountBits = kbst_pkg::CountBitsDefault,
  parameter int unsigned Index     = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kbst_pkg::tok_t tok_i,
  input  logic           claim_i,   // final pass: store key here
  input  logic [kbst_pkg::KeyW-1:0] claim_key_i,
  output kbst_pkg::tok_t tok_o,
  output kbst_pkg::rep_t rep_o
);

  localparam logic [kbst_pkg::SlotW-1:0] Idx = kbst_pkg::SlotW'(Index);

  logic [kbst_pkg::KeyW-1:0] key_q, key_d;
  logic                      vld_q, vld_d;
  logic [CountBits-1:0]      cnt_q, cnt_d;
  logic                      drt_q, drt_d;
  kbst_pkg::tok_t            tok_q, tok_d;

  logic here, hit, free;

  always_comb begin
    key_d = key_q;
    vld_d = vld_q;
    cnt_d = cnt_q;
    drt_d = drt_q;
    // token stays put once it has passed, so a paused row keeps it
    tok_d = tok_i.act ? tok_i : tok_q;
    rep_o = '0;
    rep_o.slot = Idx;
    here = tok_i.act && (tok_i.slot == Idx);
    hit  = vld_q && (key_q == tok_i.key);
    free = (cnt_q == '0) && !drt_q;
    rep_o.free = free;
    if (claim_i) begin
      key_d = claim_key_i;
      vld_d = 1'b1;
      cnt_d = CountBits'(1);
      drt_d = 1'b0;
    end else if (tok_i.act) begin
      case (tok_i.cmd)
        kbst_pkg::CMD_ACQUIRE: begin
          if (!tok_i.found) begin
            if (hit) begin
              if (cnt_q != '1) cnt_d = cnt_q + CountBits'(1);
              tok_d.found = 1'b1;
              rep_o.hit   = 1'b1;
            end else if (free && !tok_i.free_ok) begin
              tok_d.free_ok  = 1'b1;
              tok_d.free_idx = Idx;
            end
          end
        end
        kbst_pkg::CMD_WB_ALL, kbst_pkg::CMD_RELD_ALL: begin
          if (vld_q && drt_q &&
              (tok_i.wb_en || tok_i.cmd == kbst_pkg::CMD_RELD_ALL)) begin
            drt_d       = 1'b0;
            rep_o.emit  = 1'b1;
            rep_o.key   = key_q;
            rep_o.io_op = (tok_i.cmd == kbst_pkg::CMD_WB_ALL) ?
                          kbst_pkg::IoWrite : kbst_pkg::IoRead;
          end
        end
        default: begin
          if (here) begin
            rep_o.emit = 1'b1;
            if (!vld_q) begin
              rep_o.status = kbst_pkg::StInvalid;
            end else begin
              rep_o.key = key_q;
              case (tok_i.cmd)
                kbst_pkg::CMD_RELEASE: if (cnt_q != '0) cnt_d = cnt_q - CountBits'(1);
                kbst_pkg::CMD_DIRTY:   drt_d = 1'b1;
                kbst_pkg::CMD_WB_ONE: if (tok_i.wb_en) begin
                  drt_d       = 1'b0;
                  rep_o.io_op = kbst_pkg::IoWrite;
                end
                kbst_pkg::CMD_RELOAD: begin
                  drt_d       = 1'b0;
                  rep_o.io_op = kbst_pkg::IoRead;
                end
                default: ;
              endcase
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      vld_q <= 1'b0;
      cnt_q <= '0;
      drt_q <= 1'b0;
      tok_q <= '0;
    end else begin
      key_q <= key_d;
      vld_q <= vld_d;
      cnt_q <= cnt_d;
      drt_q <= drt_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
